/* sv/integer_to_radix_text_top_macros.svh */
`ifndef INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH

// Checks sampled on i_clk and held off while i_rst_n is low.
// Same-cycle implication.
`define ITRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ITRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/itrt_pkg.sv */
`timescale 1ns / 1ps

package itrt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_WIDTH = 6;
    localparam int DIGIT_WIDTH = 6;
    localparam int CHAR_WIDTH  = 7;
    localparam int STACK_DEPTH = VALUE_WIDTH;
    localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
    localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
    localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int STEP_WIDTH  = 4;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(36);

    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = CHAR_WIDTH'(8'h2d);
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(8'h30);
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A = CHAR_WIDTH'(8'h61);

    // datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE       = 3'd0;
    localparam t_op OP_LOAD       = 3'd1;
    localparam t_op OP_DIV_INIT   = 3'd2;
    localparam t_op OP_DIV_STEP   = 3'd3;
    localparam t_op OP_PUSH       = 3'd4;
    localparam t_op OP_EMIT_MINUS = 3'd5;
    localparam t_op OP_POP        = 3'd6;
    localparam t_op OP_EMIT_DIGIT = 3'd7;

    // hold conditions
    typedef logic [1:0] t_stall;
    localparam t_stall ST_NONE     = 2'd0;
    localparam t_stall ST_NO_INPUT = 2'd1;
    localparam t_stall ST_OUT_BUSY = 2'd2;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond JC_NEVER    = 3'd0;
    localparam t_cond JC_ALWAYS   = 3'd1;
    localparam t_cond JC_DIV_MORE = 3'd2;
    localparam t_cond JC_QUO_NZ   = 3'd3;
    localparam t_cond JC_NOT_NEG  = 3'd4;
    localparam t_cond JC_CNT_ZERO = 3'd5;

    typedef logic [STEP_WIDTH-1:0] t_step;

    // program steps
    localparam t_step S_IDLE      = 4'd0;
    localparam t_step S_DIV_INIT  = 4'd1;
    localparam t_step S_DIV_STEP  = 4'd2;
    localparam t_step S_PUSH      = 4'd3;
    localparam t_step S_SIGN      = 4'd4;
    localparam t_step S_MINUS     = 4'd5;
    localparam t_step S_POP       = 4'd6;
    localparam t_step S_EMIT      = 4'd7;
    localparam t_step S_LOOP      = 4'd8;

    typedef struct packed {
        t_op    op;
        t_stall stall;
        t_cond  cond;
        t_step  target;
    } t_uword;

    typedef struct packed {
        logic div_more;
        logic quo_nz;
        logic neg;
        logic cnt_zero;
        logic out_busy;
    } t_status;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            S_IDLE:     w = '{OP_LOAD,       ST_NO_INPUT, JC_NEVER,    S_IDLE};
            S_DIV_INIT: w = '{OP_DIV_INIT,   ST_NONE,     JC_NEVER,    S_IDLE};
            S_DIV_STEP: w = '{OP_DIV_STEP,   ST_NONE,     JC_DIV_MORE, S_DIV_STEP};
            S_PUSH:     w = '{OP_PUSH,       ST_NONE,     JC_QUO_NZ,   S_DIV_INIT};
            S_SIGN:     w = '{OP_NONE,       ST_NONE,     JC_NOT_NEG,  S_POP};
            S_MINUS:    w = '{OP_EMIT_MINUS, ST_OUT_BUSY, JC_NEVER,    S_IDLE};
            S_POP:      w = '{OP_POP,        ST_NONE,     JC_NEVER,    S_IDLE};
            S_EMIT:     w = '{OP_EMIT_DIGIT, ST_OUT_BUSY, JC_CNT_ZERO, S_IDLE};
            S_LOOP:     w = '{OP_NONE,       ST_NONE,     JC_ALWAYS,   S_POP};
            default:    w = '{OP_NONE,       ST_NONE,     JC_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d < DIGIT_WIDTH'(10)) begin
            c = CHAR_ZERO + CHAR_WIDTH'(d);
        end else if (d < DIGIT_WIDTH'(36)) begin
            c = CHAR_LOW_A + CHAR_WIDTH'(d) - CHAR_WIDTH'(10);
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

/* sv/itrt_value_if.sv */
`timescale 1ns / 1ps

interface itrt_value_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [itrt_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* sv/itrt_char_if.sv */
`timescale 1ns / 1ps

interface itrt_char_if;
    logic                            valid;
    logic                            ready;
    logic [itrt_pkg::CHAR_WIDTH-1:0] char_code;
    logic                            last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* sv/itrt_cfg_if.sv */
`timescale 1ns / 1ps

interface itrt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [itrt_pkg::RADIX_WIDTH-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

/* sv/itrt_seq.sv */
`timescale 1ns / 1ps

module itrt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  itrt_pkg::t_status i_status,
    output itrt_pkg::t_op     o_op,
    output logic              o_in_ready
);

    itrt_pkg::t_step  r_step;
    itrt_pkg::t_step  n_step;
    itrt_pkg::t_uword w;
    logic             stall;
    logic             jump;

    always_comb begin
        w = itrt_pkg::ucode_rom(r_step);

        case (w.stall)
            itrt_pkg::ST_NONE:     stall = 1'b0;
            itrt_pkg::ST_NO_INPUT: stall = !i_in_valid;
            itrt_pkg::ST_OUT_BUSY: stall = i_status.out_busy;
            default:               stall = 1'b0;
        endcase

        case (w.cond)
            itrt_pkg::JC_NEVER:    jump = 1'b0;
            itrt_pkg::JC_ALWAYS:   jump = 1'b1;
            itrt_pkg::JC_DIV_MORE: jump = i_status.div_more;
            itrt_pkg::JC_QUO_NZ:   jump = i_status.quo_nz;
            itrt_pkg::JC_NOT_NEG:  jump = !i_status.neg;
            itrt_pkg::JC_CNT_ZERO: jump = i_status.cnt_zero;
            default:               jump = 1'b0;
        endcase

        if (stall) begin
            n_step = r_step;
        end else if (jump) begin
            n_step = w.target;
        end else begin
            n_step = r_step + itrt_pkg::STEP_WIDTH'(1);
        end

        o_op       = stall ? itrt_pkg::OP_NONE : w.op;
        // ready depends on the step only, never on valid
        o_in_ready = (w.op == itrt_pkg::OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= itrt_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* sv/itrt_dp.sv */
`timescale 1ns / 1ps

module itrt_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  itrt_pkg::t_op                           i_op,
    input  logic signed [itrt_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic                                    i_cfg_valid,
    input  logic [itrt_pkg::RADIX_WIDTH-1:0]        i_cfg_radix,
    input  logic                                    i_out_ready,
    output itrt_pkg::t_status                       o_status,
    output logic                                    o_out_valid,
    output logic [itrt_pkg::CHAR_WIDTH-1:0]         o_out_char,
    output logic                                    o_out_last
);

    localparam int W  = itrt_pkg::VALUE_WIDTH;
    localparam int DW = itrt_pkg::DIGIT_WIDTH;

    logic [itrt_pkg::RADIX_WIDTH-1:0] r_radix;
    logic [DW-1:0]                    r_div;
    logic [W-1:0]                     r_quo;
    logic [DW-1:0]                    r_rem;
    logic [itrt_pkg::BIT_WIDTH-1:0]   r_bit;
    logic [itrt_pkg::COUNT_WIDTH-1:0] r_cnt;
    logic                             r_neg;
    logic [DW-1:0]                    r_rd;
    logic                             r_out_valid;
    logic [itrt_pkg::CHAR_WIDTH-1:0]  r_out_char;
    logic                             r_out_last;

    logic [DW-1:0] mem [itrt_pkg::STACK_DEPTH];

    logic [W-1:0]    abs_value;
    logic [DW:0]     trial;
    logic            q_bit;
    logic [DW-1:0]   eff_radix;
    logic [itrt_pkg::COUNT_WIDTH-1:0] cnt_dec;

    always_comb begin
        abs_value = i_value[W-1] ? (~i_value + W'(1)) : i_value;
        trial     = {r_rem, r_quo[W-1]};
        q_bit     = (trial >= {1'b0, r_div});
        cnt_dec   = r_cnt - itrt_pkg::COUNT_WIDTH'(1);
        if (r_radix < itrt_pkg::RADIX_MIN) begin
            eff_radix = itrt_pkg::RADIX_MIN;
        end else if (r_radix > itrt_pkg::RADIX_MAX) begin
            eff_radix = itrt_pkg::RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itrt_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    // magnitude, restoring divider and digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= '0;
            r_cnt <= '0;
            r_neg <= 1'b0;
        end else begin
            case (i_op)
                itrt_pkg::OP_LOAD: begin
                    r_quo <= abs_value;
                    r_neg <= i_value[W-1];
                    r_cnt <= '0;
                    r_div <= eff_radix;
                end
                itrt_pkg::OP_DIV_INIT: begin
                    r_rem <= '0;
                    r_bit <= '0;
                end
                itrt_pkg::OP_DIV_STEP: begin
                    r_rem <= q_bit ? DW'(trial - {1'b0, r_div}) : DW'(trial);
                    r_quo <= {r_quo[W-2:0], q_bit};
                    r_bit <= r_bit + itrt_pkg::BIT_WIDTH'(1);
                end
                itrt_pkg::OP_PUSH: begin
                    r_cnt <= r_cnt + itrt_pkg::COUNT_WIDTH'(1);
                end
                itrt_pkg::OP_POP: begin
                    r_cnt <= cnt_dec;
                end
                default: begin
                end
            endcase
        end
    end

    // digit stack
    always_ff @(posedge i_clk) begin
        if (i_op == itrt_pkg::OP_PUSH) begin
            mem[r_cnt[itrt_pkg::ADDR_WIDTH-1:0]] <= r_rem;
        end
        if (i_op == itrt_pkg::OP_POP) begin
            r_rd <= mem[cnt_dec[itrt_pkg::ADDR_WIDTH-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == itrt_pkg::OP_EMIT_MINUS || i_op == itrt_pkg::OP_EMIT_DIGIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == itrt_pkg::OP_EMIT_MINUS) begin
            r_out_char <= itrt_pkg::CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_op == itrt_pkg::OP_EMIT_DIGIT) begin
            r_out_char <= itrt_pkg::digit_char(r_rd);
            r_out_last <= (r_cnt == '0);
        end
    end

    always_comb begin
        o_status.div_more = (r_bit != itrt_pkg::BIT_WIDTH'(W - 1));
        o_status.quo_nz   = (r_quo != '0);
        o_status.neg      = r_neg;
        o_status.cnt_zero = (r_cnt == '0);
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

/* sv/integer_to_radix_text_top.sv */
`timescale 1ns / 1ps

// Converts one signed 32-bit value per input transaction into ASCII text in the base held
// in the radix register (2 to 36; 0 and 1 act as 2, 37 to 63 as 36; reset 10). Characters
// leave most significant first, negatives led by '-', digits above nine as 'a'..'z', and
// last_char marks the final character; no terminator follows. A small microcode program
// steps a shared restoring divider one quotient bit per cycle; each digit takes an init step,
// 32 divide steps and a push onto the digit stack, and each character is then popped and sent.
// One value is converted at a time: the next is taken once the last character sits in the
// output register. Radix writes are always taken and should only happen while the block is
// idle.
module integer_to_radix_text_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itrt_value_if.sink        i_value,
    itrt_cfg_if.sink          i_cfg,
    itrt_char_if.source       o_char
);

    itrt_pkg::t_op     op;
    itrt_pkg::t_status status;
    logic              in_ready;

    assign i_value.ready = in_ready;
    assign i_cfg.ready   = 1'b1;

    itrt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value.valid),
        .i_status   (status),
        .o_op       (op),
        .o_in_ready (in_ready)
    );

    itrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_value     (i_value.value),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_radix (i_cfg.radix),
        .i_out_ready (o_char.ready),
        .o_status    (status),
        .o_out_valid (o_char.valid),
        .o_out_char  (o_char.char_code),
        .o_out_last  (o_char.last_char)
    );

endmodule

/* sv/itrt_checker.sv */
`timescale 1ns / 1ps
`include "integer_to_radix_text_top_macros.svh"

module itrt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [itrt_pkg::CHAR_WIDTH-1:0] i_out_char,
    input logic                            i_out_last
);

    logic legal_char;

    assign legal_char = (i_out_char == itrt_pkg::CHAR_MINUS)
        || (i_out_char >= itrt_pkg::CHAR_ZERO && i_out_char <= itrt_pkg::CHAR_WIDTH'(8'h39))
        || (i_out_char >= itrt_pkg::CHAR_LOW_A && i_out_char <= itrt_pkg::CHAR_WIDTH'(8'h7a));

    // a new value only starts once the previous text is complete
    `ITRT_ASSERT_IMPL(a_no_overlap, i_in_valid && i_in_ready, !(i_out_valid && !i_out_last), "new value taken mid-text")
    `ITRT_ASSERT_IMPL(a_minus_not_last, i_out_valid && i_out_char == itrt_pkg::CHAR_MINUS, !i_out_last, "minus marked last")
    `ITRT_ASSERT_IMPL(a_legal_char, i_out_valid, legal_char, "illegal character code")
    `ITRT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_out_last), "stalled character changed")

endmodule

bind integer_to_radix_text_top itrt_checker u_itrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_value.valid),
    .i_in_ready  (i_value.ready),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.char_code),
    .i_out_last  (o_char.last_char)
);

/* test/tb_integer_to_radix_text_top.sv */
`timescale 1ns / 1ps

module tb_integer_to_radix_text_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int IDLE_GUARD   = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 3000;
    localparam int HOLD_AFTER   = 250;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 8;
    localparam int N_FIXED      = 4;
    localparam int PHASE_ITEMS  = 23;
    localparam int VW           = itrt_pkg::VALUE_WIDTH;
    localparam int RW           = itrt_pkg::RADIX_WIDTH;
    localparam int CW           = itrt_pkg::CHAR_WIDTH;
    localparam int DW           = itrt_pkg::DIGIT_WIDTH;
    localparam int TEXT_CHARS   = VW + 1;
    localparam int TEXT_BITS    = 8 * TEXT_CHARS;

    typedef struct packed {
        logic [CW-1:0] code;
        logic          last;
    } t_char_rec;

    // text is right-justified; an empty text means the row is predicted
    typedef struct packed {
        logic [RW-1:0]        radix;
        logic [VW-1:0]        value;
        logic [TEXT_BITS-1:0] text;
    } t_stim_row;

    typedef enum int unsigned {RX_FREE, RX_COIN, RX_SLOW, RX_PATTERN} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    itrt_value_if vin ();
    itrt_cfg_if   cfg ();
    itrt_char_if  chr ();

    integer_to_radix_text_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (vin),
        .i_cfg   (cfg),
        .o_char  (chr)
    );

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{6'd10, 32'd0,        "0"},
        '{6'd10, 32'd1,        "1"},
        '{6'd10, 32'd9,        "9"},
        '{6'd10, 32'd10,       "10"},
        '{6'd10, 32'hffffffff, "-1"},
        '{6'd10, 32'h7fffffff, "2147483647"},
        '{6'd10, 32'h80000000, "-2147483648"},
        '{6'd10, 32'd123456789, ""},
        '{6'd2,  32'd0,        "0"},
        '{6'd2,  32'd1,        "1"},
        '{6'd2,  32'h7fffffff, {"1111111111", "1111111111", "1111111111", "1"}},
        '{6'd2,  32'h80000000, {"-1", "0000000000", "0000000000", "0000000000", "0"}},
        '{6'd2,  32'hffffffff, "-1"},
        '{6'd2,  32'haaaaaaaa, ""},
        '{6'd36, 32'd35,       "z"},
        '{6'd36, 32'd36,       "10"},
        '{6'd36, 32'hffffffdd, "-z"},
        '{6'd36, 32'h7fffffff, ""},
        '{6'd36, 32'h80000000, ""},
        '{6'd16, 32'hdeadbeef, ""},
        '{6'd16, 32'h7fffffff, "7fffffff"},
        '{6'd0,  32'd5,        "101"},
        '{6'd1,  32'hfffffffd, "-11"},
        '{6'd37, 32'd36,       "10"},
        '{6'd63, 32'd1295,     "zz"}
    };

    logic [RW-1:0] fixed_radix [N_FIXED] = '{6'd2, 6'd36, 6'd0, 6'd63};

    t_char_rec     pending_chars [$];
    logic [RW-1:0] radix_now;
    int unsigned   cycle_count  = 0;
    int unsigned   chars_seen   = 0;
    int unsigned   values_sent  = 0;
    int unsigned   radix_writes = 0;
    int unsigned   mismatches   = 0;
    int unsigned   burst_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d characters still awaited",
                 cycle_count, pending_chars.size());
        $display("integer_to_radix_text_top: mismatch");
        $finish;
    end

    // Expected text of one value: sign, then digits most significant first.
    function automatic void predict_text(input logic [VW-1:0] v,
                                         input logic [RW-1:0] rad);
        logic [VW-1:0] mag;
        logic [VW-1:0] base;
        logic [DW-1:0] digits [$];
        logic [DW-1:0] d;
        t_char_rec     rec;
        if (rad < itrt_pkg::RADIX_MIN) begin
            base = VW'(itrt_pkg::RADIX_MIN);
        end else if (rad > itrt_pkg::RADIX_MAX) begin
            base = VW'(itrt_pkg::RADIX_MAX);
        end else begin
            base = VW'(rad);
        end
        // unsigned magnitude, so the most negative value wraps to 2^31
        mag = v[VW-1] ? -v : v;
        do begin
            digits.push_front(DW'(mag % base));
            mag = mag / base;
        end while (mag != '0);
        if (v[VW-1]) begin
            rec.code = itrt_pkg::CHAR_MINUS;
            rec.last = 1'b0;
            pending_chars.push_back(rec);
        end
        while (digits.size() != 0) begin
            d = digits.pop_front();
            rec.code = (d < 10) ? itrt_pkg::CHAR_ZERO + CW'(d)
                                : itrt_pkg::CHAR_LOW_A + CW'(d - 10);
            rec.last = (digits.size() == 0);
            pending_chars.push_back(rec);
        end
    endfunction

    function automatic void queue_text(input logic [TEXT_BITS-1:0] text);
        t_char_rec rec;
        for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
            if (text[i*8 +: 8] != 8'h00) begin
                rec.code = CW'(text[i*8 +: 8]);
                rec.last = (i == 0);
                pending_chars.push_back(rec);
            end
        end
    endfunction

    task automatic send_value(input logic [VW-1:0] v, input logic [TEXT_BITS-1:0] text);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                vin.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        vin.valid <= 1'b1;
        vin.value <= v;
        do begin
            @(posedge i_clk);
        end while (vin.ready !== 1'b1);
        if (text != '0) begin
            queue_text(text);
        end else begin
            predict_text(v, radix_now);
        end
        burst_left--;
        values_sent++;
    endtask

    // Radix is only changed once all text is out and the block has settled.
    task automatic write_radix(input logic [RW-1:0] r);
        vin.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.radix <= r;
        do begin
            @(posedge i_clk);
        end while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        radix_now = r;
        radix_writes++;
        burst_left = 0;
    endtask

    // Character checker and receiver stall pattern share one process.
    initial begin : char_sink
        t_char_rec   want;
        t_rx_mode    rx_mode;
        int unsigned rx_mode_left;
        int unsigned hold_left;
        logic        hold_done;
        logic [7:0]  rx_pattern;
        rx_mode_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        rx_pattern   = 8'b1011_0010;
        rx_mode      = RX_FREE;
        chr.ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && chr.valid && chr.ready) begin
                chars_seen++;
                if (pending_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("char %0d: unexpected transaction, code %h last %b",
                                 chars_seen, chr.char_code, chr.last_char);
                    end
                end else begin
                    want = pending_chars.pop_front();
                    if (chr.char_code !== want.code || chr.last_char !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("char %0d: expected code %h last %b, got code %h last %b",
                                     chars_seen, want.code, want.last,
                                     chr.char_code, chr.last_char);
                        end
                    end
                end
            end
            // one long hold-off while the sender keeps offering values
            if (!hold_done && chars_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end
            rx_mode_left--;
            rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
            if (hold_left != 0) begin
                hold_left--;
                chr.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:    chr.ready <= 1'b1;
                    RX_COIN:    chr.ready <= $urandom_range(0, 1);
                    RX_SLOW:    chr.ready <= ($urandom_range(0, 3) == 0);
                    default:    chr.ready <= rx_pattern[0];
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [VW-1:0] v;
        logic [RW-1:0] r;
        i_rst_n   = 1'b0;
        vin.valid = 1'b0;
        vin.value = '0;
        cfg.valid = 1'b0;
        cfg.radix = itrt_pkg::RADIX_RESET;
        radix_now = itrt_pkg::RADIX_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].radix != radix_now) begin
                write_radix(directed_rows[i].radix);
            end
            send_value(directed_rows[i].value, directed_rows[i].text);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            r = (p < N_FIXED) ? fixed_radix[p] : RW'($urandom_range(0, 63));
            write_radix(r);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom;
                    4:          v = $urandom_range(0, 2000);
                    5:          v = -$urandom_range(1, 2000);
                    6:          v = $urandom >> $urandom_range(0, 31);
                    7:          v = -($urandom >> $urandom_range(0, 31));
                    8: begin
                        case ($urandom_range(0, 3))
                            0:       v = '0;
                            1:       v = '1;
                            2:       v = {1'b0, {(VW-1){1'b1}}};
                            default: v = {1'b1, {(VW-1){1'b0}}};
                        endcase
                    end
                    default:    v = $urandom_range(0, 35);
                endcase
                send_value(v, '0);
            end
        end

        vin.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d values (%0d directed) across %0d radix writes",
                 values_sent, N_DIRECTED, radix_writes);
        $display("checked %0d characters, %0d mismatches", chars_seen, mismatches);
        if (mismatches == 0) begin
            $display("integer_to_radix_text_top: match");
        end else begin
            $display("integer_to_radix_text_top: mismatch");
        end
        $finish;
    end

endmodule

/* integer_to_radix_text_top.f */
+incdir+sv
sv/itrt_pkg.sv
sv/itrt_value_if.sv
sv/itrt_char_if.sv
sv/itrt_cfg_if.sv
sv/itrt_seq.sv
sv/itrt_dp.sv
sv/integer_to_radix_text_top.sv
sv/itrt_checker.sv
test/tb_integer_to_radix_text_top.sv
